[rtl/core/brtm_pkg.sv]
package brtm_pkg;

  localparam int NUM_BUTTONS = 12;
  localparam int MAP_W       = 4 * NUM_BUTTONS;

  // Fixed report bit positions.
  localparam logic [3:0] BIT_RT          = 4'd5;
  localparam logic [3:0] BIT_LT          = 4'd6;
  localparam logic [3:0] BIT_ALWAYS_HIGH = 4'd7;
  localparam logic [3:0] BIT_ORIGIN      = 4'd13;

  // Trigger mode codes.
  localparam logic [2:0] MODE_DIGITAL     = 3'd0;
  localparam logic [2:0] MODE_BOTH        = 3'd1;
  localparam logic [2:0] MODE_PLUG        = 3'd2;
  localparam logic [2:0] MODE_ANALOG_ONLY = 3'd3;
  localparam logic [2:0] MODE_AOD         = 3'd4;
  localparam logic [2:0] MODE_BOTH_OD     = 3'd5;
  localparam logic [2:0] MODE_MULT        = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BUTTON_MAP      = 3'd0;
  localparam logic [2:0] CFG_LEFT_MODE       = 3'd1;
  localparam logic [2:0] CFG_RIGHT_MODE      = 3'd2;
  localparam logic [2:0] CFG_LEFT_THRESHOLD  = 3'd3;
  localparam logic [2:0] CFG_RIGHT_THRESHOLD = 3'd4;
  localparam logic [2:0] CFG_TRICK_THRESHOLD = 3'd5;
  localparam logic [2:0] CFG_MULT_SLOPE      = 3'd6;
  localparam logic [2:0] CFG_MULT_OFFSET     = 3'd7;

  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic [12:0] phys_buttons;
    logic        origin_flag;
    logic [7:0]  left_raw;
    logic [7:0]  right_raw;
  } in_t;

  typedef struct packed {
    logic [15:0] report_buttons;
    logic [7:0]  left_out;
    logic [7:0]  right_out;
  } out_t;

  // Per-trigger status: pressed comes from the remapped word, enable from the map entry.
  typedef struct packed {
    logic pressed;
    logic enable;
  } trig_ctl_t;

endpackage

[rtl/core/brtm_remap.sv]
module brtm_remap
  import brtm_pkg::*;
(
  input  logic [12:0]      phys_buttons,
  input  logic             origin_flag,
  input  logic [MAP_W-1:0] button_map,
  input  logic [2:0]       left_mode,
  input  logic [2:0]       right_mode,
  output logic [15:0]      report_word,
  output trig_ctl_t        left_ctl,
  output trig_ctl_t        right_ctl
);

  logic [NUM_BUTTONS-1:0] src;
  logic [15:0]            init_word;
  logic [15:0]            remapped;
  logic                   clr_left;
  logic                   clr_right;

  // Source bits ordered by map entry; physical bit 7 has no entry.
  assign src = {phys_buttons[12:8], phys_buttons[6:0]};

  always_comb begin
    init_word = '0;
    init_word[BIT_ALWAYS_HIGH] = 1'b1;
    init_word[BIT_ORIGIN]      = origin_flag;
  end

  // One lane per report bit. Buttons are applied from the highest entry down,
  // so the lowest matching entry is the one that sticks.
  for (genvar j = 0; j < 16; j++) begin : g_bit
    logic [NUM_BUTTONS-1:0] match;
    logic [NUM_BUTTONS-1:0] lowest;

    always_comb begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        match[k] = (button_map[4*k +: 4] == 4'(j));
      end
    end

    assign lowest      = match & (~match + NUM_BUTTONS'(1));
    assign remapped[j] = (|match) ? (|(lowest & src)) : init_word[j];
  end

  function automatic logic clear_own(input logic [2:0] mode, input logic [2:0] other);
    logic clr;
    clr = 1'b0;
    case (mode)
      MODE_BOTH, MODE_PLUG, MODE_MULT: clr = (other == MODE_AOD);
      MODE_ANALOG_ONLY, MODE_AOD:      clr = 1'b1;
      default:                         clr = 1'b0;
    endcase
    return clr;
  endfunction

  assign clr_left  = clear_own(left_mode, right_mode);
  assign clr_right = clear_own(right_mode, left_mode);

  always_comb begin
    report_word = remapped;
    if (clr_left) begin
      report_word[BIT_LT] = 1'b0;
    end
    if (clr_right) begin
      report_word[BIT_RT] = 1'b0;
    end
  end

  assign left_ctl.pressed  = remapped[BIT_LT];
  assign left_ctl.enable   = (button_map[4*6 +: 4] == BIT_LT);
  assign right_ctl.pressed = remapped[BIT_RT];
  assign right_ctl.enable  = (button_map[4*5 +: 4] == BIT_RT);

endmodule

[rtl/core/brtm_trig_lane.sv]
module brtm_trig_lane
  import brtm_pkg::*;
(
  input  logic        clk,
  input  logic        load1,
  input  logic        load2,
  input  logic [7:0]  raw,
  input  logic [7:0]  thr,
  input  logic [2:0]  mode,
  input  logic [2:0]  opp_mode,
  input  logic [7:0]  trick,
  input  logic [15:0] slope,
  input  logic [15:0] offset,
  input  trig_ctl_t   ctl,
  output logic [7:0]  shaped
);

  logic [7:0]  a0;
  logic [23:0] tm0;
  logic [24:0] mul0;

  logic [7:0]  a1;
  logic [24:0] mul1;
  logic [7:0]  t1;
  logic [2:0]  mode1;
  logic        aod1;
  trig_ctl_t   ctl1;

  logic [32:0] prod;
  logic [16:0] scaled;
  logic [7:0]  mult_val;
  logic [7:0]  out_val;

  // First stage: trick threshold and the gain t*M + 16*B.
  assign a0   = (raw <= trick) ? 8'd0 : raw;
  assign tm0  = 24'(thr) * 24'(slope);
  assign mul0 = {1'b0, tm0} + {5'b0, offset, 4'b0};

  always_ff @(posedge clk) begin
    if (load1) begin
      a1    <= a0;
      mul1  <= mul0;
      t1    <= thr;
      mode1 <= mode;
      aod1  <= (opp_mode == MODE_AOD);
      ctl1  <= ctl;
    end
  end

  // Second stage: apply the gain, drop 16 fraction bits, saturate.
  assign prod     = 33'(a1) * 33'(mul1);
  assign scaled   = prod[32:16];
  assign mult_val = (|scaled[16:8]) ? SAT_MAX : scaled[7:0];

  always_comb begin
    case (mode1)
      MODE_BOTH, MODE_ANALOG_ONLY: out_val = aod1 ? 8'd0 : a1;
      MODE_PLUG:                   out_val = aod1 ? 8'd0 : ((a1 > t1) ? t1 : a1);
      MODE_AOD, MODE_BOTH_OD:      out_val = ctl1.pressed ? t1 : 8'd0;
      MODE_MULT:                   out_val = aod1 ? 8'd0 : mult_val;
      default:                     out_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      shaped <= ctl1.enable ? out_val : 8'd0;
    end
  end

endmodule

[rtl/core/button_remap_trigger_mode.sv]
// An accepted input transaction is registered in s1, then in s2, which
// holds its result. Throughput: one transaction per cycle while out_stall
// is low; both trigger lanes run a two-stage pipeline, gain multiply and
// scaling multiply in separate stages; remap lanes feed the same stages.
// Reset (synchronous, rst high) empties the pipeline and loads the
// configuration registers with their default values.
module button_remap_trigger_mode
  import brtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [MAP_W-1:0] button_map;
  logic [2:0]       left_mode;
  logic [2:0]       right_mode;
  logic [7:0]       left_threshold;
  logic [7:0]       right_threshold;
  logic [7:0]       trick_threshold;
  logic [15:0]      mult_slope;
  logic [15:0]      mult_offset;

  logic [15:0] word0;
  trig_ctl_t   left_ctl;
  trig_ctl_t   right_ctl;

  logic        s1_valid;
  logic        s2_valid;
  logic [15:0] s1_word;
  logic [15:0] s2_word;
  logic        s1_adv;
  logic        s2_adv;
  logic [7:0]  left_shaped;
  logic [7:0]  right_shaped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_map      <= '0;
      left_mode       <= MODE_BOTH;
      right_mode      <= MODE_BOTH;
      left_threshold  <= '0;
      right_threshold <= '0;
      trick_threshold <= '0;
      mult_slope      <= '0;
      mult_offset     <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUTTON_MAP:      button_map      <= cfg_data[MAP_W-1:0];
        CFG_LEFT_MODE:       left_mode       <= cfg_data[2:0];
        CFG_RIGHT_MODE:      right_mode      <= cfg_data[2:0];
        CFG_LEFT_THRESHOLD:  left_threshold  <= cfg_data[7:0];
        CFG_RIGHT_THRESHOLD: right_threshold <= cfg_data[7:0];
        CFG_TRICK_THRESHOLD: trick_threshold <= cfg_data[7:0];
        CFG_MULT_SLOPE:      mult_slope      <= cfg_data[15:0];
        CFG_MULT_OFFSET:     mult_offset     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  brtm_remap u_remap (
    .phys_buttons (in_data.phys_buttons),
    .origin_flag  (in_data.origin_flag),
    .button_map   (button_map),
    .left_mode    (left_mode),
    .right_mode   (right_mode),
    .report_word  (word0),
    .left_ctl     (left_ctl),
    .right_ctl    (right_ctl)
  );

  // A stage takes new data whenever it is empty or the stage after it can move.
  assign s2_adv   = !s2_valid || !out_stall;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= in_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_word <= word0;
    end
    if (s2_adv) begin
      s2_word <= s1_word;
    end
  end

  brtm_trig_lane u_left (
    .clk        (clk),
    .load1      (s1_adv),
    .load2      (s2_adv),
    .raw        (in_data.left_raw),
    .thr        (left_threshold),
    .mode       (left_mode),
    .opp_mode   (right_mode),
    .trick      (trick_threshold),
    .slope      (mult_slope),
    .offset     (mult_offset),
    .ctl        (left_ctl),
    .shaped     (left_shaped)
  );

  brtm_trig_lane u_right (
    .clk        (clk),
    .load1      (s1_adv),
    .load2      (s2_adv),
    .raw        (in_data.right_raw),
    .thr        (right_threshold),
    .mode       (right_mode),
    .opp_mode   (left_mode),
    .trick      (trick_threshold),
    .slope      (mult_slope),
    .offset     (mult_offset),
    .ctl        (right_ctl),
    .shaped     (right_shaped)
  );

  // Merge the remap word with both trigger lanes.
  assign out_valid               = s2_valid;
  assign out_data.report_buttons = s2_word;
  assign out_data.left_out       = left_shaped;
  assign out_data.right_out      = right_shaped;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction did not enter the first stage");

  a_left_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (button_map[4*6 +: 4] != BIT_LT)) |-> (out_data.left_out == 8'd0))
    else $error("left trigger output nonzero while its map entry is moved");

endmodule

[bench/tb_button_remap_trigger_mode.sv]
`timescale 1ns / 100ps

module tb_button_remap_trigger_mode;
  import brtm_pkg::*;

  // The package has no name for the spare mode code; it must act like digital only.
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 32;
  localparam int PHASE_SAMPLES = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_BUTTON_MAP;
  logic [47:0] cfg_data = '0;

  // Register contents as the block should hold them, starting from reset values.
  logic [47:0] cur_map = '0;
  logic [2:0]  cur_left_mode = MODE_BOTH;
  logic [2:0]  cur_right_mode = MODE_BOTH;
  logic [7:0]  cur_left_level = '0;
  logic [7:0]  cur_right_level = '0;
  logic [7:0]  cur_trick = '0;
  logic [15:0] cur_slope = '0;
  logic [15:0] cur_offset = 16'd4096;

  in_t  pending_samples[$];
  out_t expected_reports[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   send_gap = 0;
  int   stall_left = 0;

  button_remap_trigger_mode u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("button_remap_trigger_mode regression: fail");
      $finish;
    end
  end

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic trigger_bit_cleared(logic [2:0] mode, logic [2:0] other);
    case (mode)
      MODE_BOTH, MODE_PLUG, MODE_MULT: return other == MODE_AOD;
      MODE_ANALOG_ONLY, MODE_AOD: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] shape_trigger(logic [7:0] raw, logic [7:0] level,
      logic pressed, logic enabled, logic [2:0] mode, logic [2:0] other);
    logic [7:0]  a;
    logic [63:0] gain;
    logic [63:0] scaled;
    logic [7:0]  shaped;
    a = (raw <= cur_trick) ? 8'd0 : raw;
    shaped = '0;
    case (mode)
      MODE_BOTH, MODE_ANALOG_ONLY: begin
        if (other != MODE_AOD) shaped = a;
      end
      MODE_PLUG: begin
        if (other != MODE_AOD) shaped = (a > level) ? level : a;
      end
      MODE_AOD, MODE_BOTH_OD: begin
        if (pressed) shaped = level;
      end
      MODE_MULT: begin
        if (other != MODE_AOD) begin
          // Slope is in 2^-16 units, intercept in 2^-12, hence the factor 16.
          gain = 64'(level) * 64'(cur_slope) + (64'(cur_offset) << 4);
          scaled = (64'(a) * gain) >> 16;
          shaped = (scaled > 64'(SAT_MAX)) ? SAT_MAX : scaled[7:0];
        end
      end
      default: shaped = '0;
    endcase
    return enabled ? shaped : 8'd0;
  endfunction

  function automatic out_t remap_and_shape(in_t s);
    out_t        r;
    logic [15:0] word;
    logic [3:0]  dst;
    logic        left_hit;
    logic        right_hit;
    int          lane;
    int          src;
    word = '0;
    word[BIT_ALWAYS_HIGH] = 1'b1;
    word[BIT_ORIGIN] = s.origin_flag;
    // Highest physical bit goes first, so a lower button wins a shared target.
    for (src = 12; src >= 0; src--) begin
      if (src != BIT_ALWAYS_HIGH) begin
        lane = (src < BIT_ALWAYS_HIGH) ? src : src - 1;
        dst = cur_map[4*lane +: 4];
        word[dst] = s.phys_buttons[src];
      end
    end
    left_hit = word[BIT_LT];
    right_hit = word[BIT_RT];
    if (trigger_bit_cleared(cur_left_mode, cur_right_mode)) word[BIT_LT] = 1'b0;
    if (trigger_bit_cleared(cur_right_mode, cur_left_mode)) word[BIT_RT] = 1'b0;
    r.report_buttons = word;
    r.left_out = shape_trigger(s.left_raw, cur_left_level, left_hit,
        cur_map[4*BIT_LT +: 4] == BIT_LT, cur_left_mode, cur_right_mode);
    r.right_out = shape_trigger(s.right_raw, cur_right_level, right_hit,
        cur_map[4*BIT_RT +: 4] == BIT_RT, cur_right_mode, cur_left_mode);
    return r;
  endfunction

  function automatic logic [47:0] identity_map();
    logic [47:0] m;
    int          k;
    for (k = 0; k < NUM_BUTTONS; k++) begin
      m[4*k +: 4] = 4'((k < BIT_ALWAYS_HIGH) ? k : k + 1);
    end
    return m;
  endfunction

  function automatic logic [47:0] random_map();
    logic [47:0] m;
    int          n;
    m = identity_map();
    n = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
    repeat (n) m[4*$urandom_range(NUM_BUTTONS - 1) +: 4] = 4'($urandom_range(15));
    // Keep both analog triggers enabled most of the time.
    if ($urandom_range(3) != 0) begin
      m[4*BIT_LT +: 4] = BIT_LT;
      m[4*BIT_RT +: 4] = BIT_RT;
    end
    return m;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_trick();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'($urandom_range(255));
      default: return 8'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [15:0] pick_wide();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Raw readings cluster around the trick threshold to hit both sides of it.
  function automatic logic [7:0] pick_raw();
    case ($urandom_range(3))
      0: return cur_trick;
      1: return cur_trick + 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_t random_sample();
    in_t s;
    s.phys_buttons = 13'($urandom_range(13'h1FFF));
    s.origin_flag = 1'($urandom_range(1));
    s.left_raw = pick_raw();
    s.right_raw = pick_raw();
    return s;
  endfunction

  task automatic queue_sample(logic [12:0] phys, logic origin, logic [7:0] lraw,
      logic [7:0] rraw);
    in_t s;
    s.phys_buttons = phys;
    s.origin_flag = origin;
    s.left_raw = lraw;
    s.right_raw = rraw;
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BUTTON_MAP:      cur_map = value;
      CFG_LEFT_MODE:       cur_left_mode = value[2:0];
      CFG_RIGHT_MODE:      cur_right_mode = value[2:0];
      CFG_LEFT_THRESHOLD:  cur_left_level = value[7:0];
      CFG_RIGHT_THRESHOLD: cur_right_level = value[7:0];
      CFG_TRICK_THRESHOLD: cur_trick = value[7:0];
      CFG_MULT_SLOPE:      cur_slope = value[15:0];
      CFG_MULT_OFFSET:     cur_offset = value[15:0];
      default: ;
    endcase
  endtask

  // Called at a rising edge with the block idle; returns at a rising edge.
  task automatic load_settings(logic [47:0] map, logic [2:0] lmode, logic [2:0] rmode,
      logic [7:0] llevel, logic [7:0] rlevel, logic [7:0] trick, logic [15:0] slope,
      logic [15:0] offset);
    write_reg(CFG_BUTTON_MAP, map);
    write_reg(CFG_LEFT_MODE, 48'(lmode));
    write_reg(CFG_RIGHT_MODE, 48'(rmode));
    write_reg(CFG_LEFT_THRESHOLD, 48'(llevel));
    write_reg(CFG_RIGHT_THRESHOLD, 48'(rlevel));
    write_reg(CFG_TRICK_THRESHOLD, 48'(trick));
    write_reg(CFG_MULT_SLOPE, 48'(slope));
    write_reg(CFG_MULT_OFFSET, 48'(offset));
    cfg_valid <= 1'b0;
  endtask

  // Sampling at the falling edge sees everything the rising edge updated.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) expected_reports.push_back(remap_and_shape(in_data));
      // A stalled transaction is held unchanged.
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(send_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result %h arrived with nothing expected", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_buttons", want.report_buttons, out_data.report_buttons);
          check_field("left_out", 16'(want.left_out), 16'(out_data.left_out));
          check_field("right_out", 16'(want.right_out), 16'(out_data.right_out));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(recv_idle_pct);
      end
    end
  end

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values: every button lands on bit 0, so both analog outputs stay off.
    queue_sample(13'h0000, 1'b0, 8'd0, 8'd0);
    queue_sample(13'h1FFF, 1'b1, 8'd255, 8'd255);
    queue_sample(13'h0001, 1'b0, 8'd128, 8'd1);
    wait_idle();

    // Multiplier at its largest gain saturates; a zero input stays zero.
    load_settings(identity_map(), MODE_MULT, MODE_MULT, 8'd255, 8'd255, 8'd0,
        16'hFFFF, 16'hFFFF);
    queue_sample(13'h0000, 1'b0, 8'd255, 8'd1);
    queue_sample(13'h1F7F, 1'b1, 8'd1, 8'd255);
    queue_sample(13'h0AAA, 1'b0, 8'd2, 8'd0);
    wait_idle();

    // Analog on digital forces the other trigger's output and bit to zero.
    load_settings(identity_map(), MODE_AOD, MODE_PLUG, 8'd200, 8'd100, 8'd50,
        16'h1234, 16'h0800);
    queue_sample(13'h0040, 1'b0, 8'd50, 8'd51);
    queue_sample(13'h0020, 1'b1, 8'd51, 8'd255);
    queue_sample(13'h1FFF, 1'b0, 8'd255, 8'd0);
    queue_sample(13'h0000, 1'b0, 8'd255, 8'd255);
    wait_idle();

    // A trick threshold at full scale zeroes every raw reading.
    load_settings(identity_map(), MODE_BOTH_OD, MODE_ANALOG_ONLY, 8'd0, 8'd255, 8'd255,
        16'h0001, 16'h0001);
    queue_sample(13'h0060, 1'b0, 8'd255, 8'd255);
    queue_sample(13'h0000, 1'b1, 8'd10, 8'd10);
    wait_idle();

    load_settings(identity_map(), MODE_DIGITAL, MODE_UNUSED, 8'd77, 8'd88, 8'd0,
        16'd0, 16'd0);
    queue_sample(13'h1FFF, 1'b1, 8'd200, 8'd200);
    queue_sample(13'h0000, 1'b0, 8'd0, 8'd255);
    wait_idle();

    // All buttons collide on bit 15; the analog outputs are disabled.
    load_settings(48'hFFFF_FFFF_FFFF, MODE_PLUG, MODE_MULT, 8'd255, 8'd0, 8'd0,
        16'd0, 16'd0);
    queue_sample(13'h1555, 1'b1, 8'd200, 8'd3);
    queue_sample(13'h0AAA, 1'b0, 8'd9, 8'd255);
    wait_idle();

    // Targets on the always-high and origin bits, triggers kept on their own bits.
    load_settings(48'hD7D7_D657_D7D7, MODE_BOTH, MODE_BOTH, 8'd128, 8'd64, 8'd5,
        16'h8000, 16'h1000);
    queue_sample(13'h1FFF, 1'b0, 8'd6, 8'd5);
    queue_sample(13'h0000, 1'b1, 8'd255, 8'd128);
    queue_sample(13'h1F00, 1'b0, 8'd100, 8'd200);
    wait_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      send_idle_pct = (phase % 4 == 0) ? 0 : $urandom_range(60, 5);
      recv_idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(60, 5);
      load_settings(random_map(), 3'($urandom_range(MODE_MULT)),
          3'($urandom_range(MODE_MULT)), pick_level(), pick_level(), pick_trick(),
          pick_wide(), pick_wide());
      repeat (PHASE_SAMPLES) pending_samples.push_back(random_sample());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("button_remap_trigger_mode regression: pass");
    end else begin
      $display("button_remap_trigger_mode regression: fail");
    end
    $finish;
  end

endmodule
